### hw/rtl/sam_pkg.sv
// Package for the suffix automaton builder: word types, opcodes and defaults.
// Depends on nothing; used by the top level.
package sam_pkg;

  localparam int unsigned MaxNodesDef = 8192;
  localparam int unsigned AlphabetDef = 27;

  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [4:0] symbol;
    logic       first_of_pattern;
    logic       last_of_pattern;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic        answer_ready;
    logic        overflow;
    logic [13:0] nodes_used;
  } out_word_t;

endpackage

### hw/rtl/sam_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing; instantiated by the suffix automaton top level.
module sam_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/suffix_automaton_builder_unit.sv
// Top level of the suffix automaton builder: sequencer around a node store and a
// transition store. Depends on sam_pkg and sam_ram.

// The block builds a suffix automaton online and answers substring queries. After
// reset it clears the root's transition row and node word and accepts no word then.
// A query word is answered straight from idle when the cursor is already invalid and
// the word does not start a pattern, or when the symbol is out of range; otherwise it
// waits for one transition store read. An insert word that overflows or carries an
// out-of-range symbol is also answered straight from idle. A real insert sets up the
// new node and clears its row, then walks the suffix links, each step a read of the
// transition and node stores followed by the check. When the walk stops at an existing
// transition, a further step compares the lengths; a clone then adds the node writes
// and the row copy, plus a redirect walk of the same read-then-check steps. The chain
// length depends on the text. A result waits in an output register; the next word is
// taken once the sequencer is idle and no result is held back by out_stall_i.
module suffix_automaton_builder_unit #(
  parameter int unsigned MAX_NODES = sam_pkg::MaxNodesDef,
  parameter int unsigned ALPHABET  = sam_pkg::AlphabetDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sam_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sam_pkg::out_word_t out_word_o
);
  import sam_pkg::*;

  localparam int unsigned ND_W  = $clog2(MAX_NODES);
  localparam int unsigned NC_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned TDEP  = MAX_NODES * ALPHABET;
  localparam int unsigned TA_W  = $clog2(TDEP);
  localparam int unsigned CW    = $clog2(ALPHABET + 1);
  localparam int unsigned NW_W  = 2 * ND_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_QWAIT, S_ILEN, S_ICLR, S_W1RD, S_W1CHK, S_QLEN,
    S_CLA, S_CLB, S_CLC, S_COPY, S_W2RD, S_W2CHK
  } state_e;

  // Node word: length in the upper half, suffix link in the lower half.
  typedef struct packed {
    logic [ND_W-1:0] len;
    logic [ND_W-1:0] link;
  } node_t;

  function automatic logic [TA_W-1:0] slot(input logic [ND_W-1:0] node,
                                           input logic [8:0] s);
    slot = TA_W'(node) * TA_W'(ALPHABET) + TA_W'(s);
  endfunction

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [ND_W-1:0] p_q, p_d, q_q, q_d, cur_q, cur_d, cl_q, cl_d;
  logic [ND_W-1:0] lenp_q, lenp_d, lencur_q, lencur_d, qlen_q, qlen_d, qlink_q, qlink_d;
  logic [ND_W-1:0] last_q, last_d, cursor_q, cursor_d;
  logic            cvalid_q, cvalid_d;
  logic [NC_W-1:0] nc_q, nc_d;
  logic [4:0]      sym_q, sym_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q, out_d;

  logic            t_we, n_we;
  logic [TA_W-1:0] t_waddr, t_raddr;
  logic [ND_W-1:0] t_wdata, t_rdata;
  logic [ND_W-1:0] n_waddr, n_raddr;
  node_t           n_wdata, n_rdata;
  logic [NW_W-1:0] n_rdata_raw;

  logic            accept;
  logic            sym_ok;
  logic [ND_W-1:0] qstart;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign n_rdata     = node_t'(n_rdata_raw);
  assign sym_ok      = 9'(in_word_i.symbol) < 9'(ALPHABET);
  assign qstart      = in_word_i.first_of_pattern ? '0 : cursor_q;

  sam_ram #(.DEPTH(TDEP), .WIDTH(ND_W)) u_trans (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  sam_ram #(.DEPTH(MAX_NODES), .WIDTH(NW_W)) u_node (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (NW_W'(n_wdata)),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata_raw)
  );

  // Sequencer: drives both stores and prepares the result word.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    q_d         = q_q;
    cur_d       = cur_q;
    cl_d        = cl_q;
    lenp_d      = lenp_q;
    lencur_d    = lencur_q;
    qlen_d      = qlen_q;
    qlink_d     = qlink_q;
    last_d      = last_q;
    cursor_d    = cursor_q;
    cvalid_d    = cvalid_q;
    nc_d        = nc_q;
    sym_d       = sym_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    t_we        = 1'b0;
    t_waddr     = slot(p_q, 9'(sym_q));
    t_wdata     = cur_q;
    t_raddr     = slot(p_q, 9'(sym_q));
    n_we        = 1'b0;
    n_waddr     = cur_q;
    n_wdata     = '{len: lencur_q, link: '0};
    n_raddr     = p_q;

    case (state_q)
      // Clear the root's transition row and node word after reset.
      S_INIT: begin
        t_we    = 1'b1;
        t_waddr = slot('0, 9'(cnt_q));
        t_wdata = '0;
        n_we    = 1'b1;
        n_waddr = '0;
        n_wdata = '0;
        if (cnt_q == CW'(ALPHABET - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        n_raddr = last_q;
        t_raddr = slot(qstart, 9'(in_word_i.symbol));
        if (accept) begin
          sym_d   = in_word_i.symbol;
          out_d   = '{found: 1'b0, answer_ready: 1'b0, overflow: 1'b0,
                      nodes_used: 14'(nc_q)};
          if (in_word_i.opcode == OpQuery) begin
            out_d.answer_ready = in_word_i.last_of_pattern;
            if (in_word_i.first_of_pattern || cvalid_q) begin
              if (sym_ok) begin
                cursor_d = qstart;
                state_d  = S_QWAIT;
              end else begin
                cvalid_d    = 1'b0;
                cursor_d    = '0;
                out_valid_d = 1'b1;
              end
            end else begin
              out_valid_d = 1'b1;
            end
          end else if ((NC_W + 1)'(nc_q) + (NC_W + 1)'(2) > (NC_W + 1)'(MAX_NODES)) begin
            out_d.overflow = 1'b1;
            out_valid_d    = 1'b1;
          end else if (!sym_ok) begin
            out_valid_d = 1'b1;
          end else begin
            cur_d   = ND_W'(nc_q);
            nc_d    = nc_q + 1'b1;
            p_d     = last_q;
            cnt_d   = '0;
            state_d = S_ILEN;
          end
        end
      end

      // Query step: the transition read has returned.
      S_QWAIT: begin
        if (t_rdata == '0) begin
          cvalid_d = 1'b0;
          cursor_d = '0;
        end else begin
          cvalid_d = 1'b1;
          cursor_d = t_rdata;
        end
        out_d.found = (t_rdata != '0);
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      // New node takes the last node's length plus one.
      S_ILEN: begin
        lencur_d = n_rdata.len + 1'b1;
        n_we     = 1'b1;
        n_waddr  = cur_q;
        n_wdata  = '{len: n_rdata.len + 1'b1, link: '0};
        state_d  = S_ICLR;
      end

      // Clear the new node's transition row.
      S_ICLR: begin
        t_we    = 1'b1;
        t_waddr = slot(cur_q, 9'(cnt_q));
        t_wdata = '0;
        if (cnt_q == CW'(ALPHABET - 1)) begin
          cnt_d   = '0;
          state_d = S_W1RD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_W1RD: begin
        state_d = S_W1CHK;
      end

      // First walk: add transitions to the new node along suffix links.
      S_W1CHK: begin
        if (t_rdata == '0) begin
          t_we    = 1'b1;
          t_wdata = cur_q;
          if (p_q == '0) begin
            last_d      = cur_q;
            out_d.nodes_used = 14'(nc_q);
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            p_d     = n_rdata.link;
            state_d = S_W1RD;
          end
        end else begin
          q_d     = t_rdata;
          lenp_d  = n_rdata.len;
          state_d = S_QLEN;
        end
        n_raddr = q_d;
      end

      // Compare lengths to decide between a plain link and a clone.
      S_QLEN: begin
        qlen_d  = n_rdata.len;
        qlink_d = n_rdata.link;
        if (lenp_q + 1'b1 == n_rdata.len) begin
          n_we        = 1'b1;
          n_wdata     = '{len: lencur_q, link: q_q};
          last_d      = cur_q;
          out_d.nodes_used = 14'(nc_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cl_d    = ND_W'(nc_q);
          nc_d    = nc_q + 1'b1;
          state_d = S_CLA;
        end
      end

      S_CLA: begin
        n_we    = 1'b1;
        n_waddr = cl_q;
        n_wdata = '{len: lenp_q + 1'b1, link: qlink_q};
        state_d = S_CLB;
      end

      S_CLB: begin
        n_we    = 1'b1;
        n_waddr = q_q;
        n_wdata = '{len: qlen_q, link: cl_q};
        state_d = S_CLC;
      end

      S_CLC: begin
        n_we    = 1'b1;
        n_waddr = cur_q;
        n_wdata = '{len: lencur_q, link: cl_q};
        cnt_d   = '0;
        state_d = S_COPY;
      end

      // Copy the row of q into the clone: read one slot, write the previous one.
      S_COPY: begin
        t_raddr = slot(q_q, 9'(cnt_q));
        if (cnt_q != '0) begin
          t_we    = 1'b1;
          t_waddr = slot(cl_q, 9'(cnt_q - 1'b1));
          t_wdata = t_rdata;
        end
        if (cnt_q == CW'(ALPHABET)) begin
          cnt_d   = '0;
          state_d = S_W2RD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_W2RD: begin
        state_d = S_W2CHK;
      end

      // Second walk: redirect transitions that point at q to the clone.
      S_W2CHK: begin
        if (t_rdata == q_q) begin
          t_we    = 1'b1;
          t_wdata = cl_q;
          if (p_q == '0) begin
            last_d      = cur_q;
            out_d.nodes_used = 14'(nc_q);
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            p_d     = n_rdata.link;
            state_d = S_W2RD;
          end
        end else begin
          last_d      = cur_q;
          out_d.nodes_used = 14'(nc_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      last_q      <= '0;
      nc_q        <= NC_W'(1);
      cursor_q    <= '0;
      cvalid_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      nc_q        <= nc_d;
      cursor_q    <= cursor_d;
      cvalid_q    <= cvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the insert sequence and the result word.
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    q_q      <= q_d;
    cur_q    <= cur_d;
    cl_q     <= cl_d;
    lenp_q   <= lenp_d;
    lencur_q <= lencur_d;
    qlen_q   <= qlen_d;
    qlink_q  <= qlink_d;
    sym_q    <= sym_d;
    out_q    <= out_d;
  end

endmodule

### bench/tb_suffix_automaton_builder_unit.sv
// Testbench for suffix_automaton_builder_unit: random and directed insert and query words,
// checked against a behavioral suffix automaton kept in the bench. Depends on sam_pkg.
module tb_suffix_automaton_builder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sam_pkg::*;

  localparam int unsigned NodeMax = 8192;
  localparam int unsigned SymCount = 27;
  localparam int unsigned SepSym = 26;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;

  suffix_automaton_builder_unit dut (.*);

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Bench copy of the automaton.
  int unsigned len_mem [NodeMax];
  int unsigned link_mem [NodeMax];
  int unsigned trans_mem [NodeMax*SymCount];
  int unsigned tail_node, node_total, cursor_node;
  bit cursor_ok;

  in_word_t word_queue[$];
  out_word_t answer_queue[$];
  int errors = 0;
  bit stim_done = 1'b0;

  task automatic report_mismatch(input string what, input int unsigned got, exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  // Appends one symbol to the automaton, cloning where lengths disagree.
  function automatic void grow_automaton(input int unsigned c);
    int unsigned cur, p, q, cl;
    bit p_ok;
    cur = node_total++;
    p = tail_node;
    p_ok = 1'b1;
    for (int i = 0; i < SymCount; i++) trans_mem[cur*SymCount+i] = 0;
    len_mem[cur] = len_mem[tail_node] + 1;
    link_mem[cur] = 0;
    while (p_ok && trans_mem[p*SymCount+c] == 0) begin
      trans_mem[p*SymCount+c] = cur;
      if (p == 0) p_ok = 1'b0; else p = link_mem[p];
    end
    if (p_ok) begin
      q = trans_mem[p*SymCount+c];
      if (len_mem[p] + 1 == len_mem[q]) begin
        link_mem[cur] = q;
      end else begin
        cl = node_total++;
        for (int i = 0; i < SymCount; i++) trans_mem[cl*SymCount+i] = trans_mem[q*SymCount+i];
        link_mem[cl] = link_mem[q];
        len_mem[cl] = len_mem[p] + 1;
        link_mem[cur] = cl;
        link_mem[q] = cl;
        while (p_ok && trans_mem[p*SymCount+c] == q) begin
          trans_mem[p*SymCount+c] = cl;
          if (p == 0) p_ok = 1'b0; else p = link_mem[p];
        end
      end
    end
    tail_node = cur;
  endfunction

  // Computes the result word that one accepted input word produces.
  function automatic out_word_t predict_answer(input in_word_t w);
    out_word_t r;
    int unsigned nxt;
    r = '0;
    if (w.opcode == OpInsert) begin
      if (node_total + 2 > NodeMax) r.overflow = 1'b1;
      else if (w.symbol < SymCount) grow_automaton(w.symbol);
    end else begin
      if (w.first_of_pattern) begin
        cursor_node = 0;
        cursor_ok = 1'b1;
      end
      if (cursor_ok) begin
        nxt = (w.symbol < SymCount) ? trans_mem[cursor_node*SymCount+w.symbol] : 0;
        if (nxt == 0) begin
          cursor_ok = 1'b0;
          cursor_node = 0;
        end else begin
          cursor_node = nxt;
        end
      end
      r.found = cursor_ok;
      r.answer_ready = w.last_of_pattern;
    end
    r.nodes_used = node_total[13:0];
    return r;
  endfunction

  // Driver: bursts of words with random gaps in between.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        answer_queue = {answer_queue, predict_answer(in_word_i)};
        void'(word_queue.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (word_queue.size() > 0 && !(in_valid_i && !in_stall_o &&
                                                word_queue.size() == 0)) begin
          in_valid_i <= 1'b1;
          in_word_i <= word_queue[0];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern for the receiving side.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (answer_queue.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          out_word_t e;
          e = answer_queue.pop_front();
          if (out_word_o.found !== e.found) report_mismatch("found", out_word_o.found, e.found);
          if (out_word_o.answer_ready !== e.answer_ready)
            report_mismatch("answer_ready", out_word_o.answer_ready, e.answer_ready);
          if (out_word_o.overflow !== e.overflow)
            report_mismatch("overflow", out_word_o.overflow, e.overflow);
          if (out_word_o.nodes_used !== e.nodes_used)
            report_mismatch("nodes_used", out_word_o.nodes_used, e.nodes_used);
        end
      end
      stall_phase = (stall_phase + 1) % 200;
      if (stall_phase < 60) out_stall_i <= 1'b0;
      else if (stall_phase < 120) out_stall_i <= ($urandom_range(0, 2) == 0);
      else out_stall_i <= ($urandom_range(0, 4) != 0);
    end
  end

  function automatic in_word_t make_word(input logic op, input int unsigned sym,
                                         input logic fst, input logic lst);
    in_word_t w;
    w.opcode = op;
    w.symbol = sym[4:0];
    w.first_of_pattern = fst;
    w.last_of_pattern = lst;
    return w;
  endfunction

  // Queues a query for a substring of the text, or a random pattern.
  task automatic queue_pattern(input int unsigned text[$], input bit from_text);
    int unsigned n, start;
    n = $urandom_range(1, 6);
    start = (text.size() > n) ? $urandom_range(0, text.size() - n) : 0;
    for (int i = 0; i < n; i++) begin
      int unsigned s;
      s = (from_text && start + i < text.size()) ? text[start+i] : $urandom_range(0, 3);
      word_queue = {word_queue, make_word(OpQuery, s, i == 0, i == n - 1)};
    end
  endtask

  initial begin
    int unsigned text[$];
    int unsigned sym;
    string seed;
    len_mem[0] = 0;
    foreach (trans_mem[i]) trans_mem[i] = 0;
    tail_node = 0;
    node_total = 1;
    cursor_node = 0;
    cursor_ok = 1'b1;
    seed = "abbab";

    // Directed: queries on an empty text, a cloning text, extremes of the symbol field.
    word_queue = {word_queue, make_word(OpQuery, 0, 1, 1)};
    word_queue = {word_queue, make_word(OpInsert, 31, 1, 1)};
    foreach (seed[i]) begin
      word_queue = {word_queue, make_word(OpInsert, int'(seed[i] - "a"), 0, 0)};
    end
    word_queue = {word_queue, make_word(OpInsert, SepSym, 0, 0)};
    word_queue = {word_queue, make_word(OpInsert, 25, 0, 0)};
    word_queue = {word_queue, make_word(OpQuery, 1, 1, 0)};
    word_queue = {word_queue, make_word(OpQuery, 0, 0, 0)};
    word_queue = {word_queue, make_word(OpInsert, 1, 0, 0)};
    word_queue = {word_queue, make_word(OpQuery, 1, 0, 1)};
    word_queue = {word_queue, make_word(OpQuery, 27, 1, 0)};
    word_queue = {word_queue, make_word(OpQuery, 0, 0, 1)};
    word_queue = {word_queue, make_word(OpQuery, SepSym, 1, 0)};
    word_queue = {word_queue, make_word(OpQuery, 25, 0, 1)};
    word_queue = {word_queue, make_word(OpQuery, 31, 0, 1)};
    text = '{0, 1, 1, 0, 1, 26, 25, 1};

    // Random: mostly small-alphabet text with queries drawn from it.
    while (word_queue.size() < 950) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          sym = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 2);
          word_queue = {word_queue, make_word(OpInsert, sym, 1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1)))};
          if (sym < SymCount) text = {text, sym};
        end
        4, 5, 6: queue_pattern(text, 1'b1);
        7: queue_pattern(text, 1'b0);
        default: word_queue = {word_queue, make_word(OpQuery, $urandom_range(0, 31),
                                                     1'($urandom_range(0, 1)),
                                                     1'($urandom_range(0, 1)))};
      endcase
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (word_queue.size() == 0 && answer_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && answer_queue.size() == 0) begin
      $display("PASS suffix_automaton_builder_unit");
    end else begin
      $display("FAIL suffix_automaton_builder_unit");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #50ms;
    $display("FAIL suffix_automaton_builder_unit");
    $finish;
  end

endmodule
